>>> rtl/csbf_pkg.sv
// Shared types and constants of the CRT scanline bloom filter.
// Used by csbf_ctrl, csbf_dp and the top level; no dependencies.
package csbf_pkg;

    localparam int CFG_W = 11;
    localparam int PIX_W = 24;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [1:0] RD_CTR   = 2'd0;
    localparam logic [1:0] RD_LEFT  = 2'd1;
    localparam logic [1:0] RD_RIGHT = 2'd2;
    localparam logic [1:0] RD_UP    = 2'd3;

    localparam logic [10:0] DEF_WIDTH  = 11'd640;
    localparam logic [10:0] DEF_HEIGHT = 11'd480;

    localparam logic [7:0]  DARK_MUL = 8'd222;
    localparam logic [9:0]  KNEE_SUM = 10'd561;
    localparam logic [25:0] RECIP    = 26'd59886255;
    localparam int          RECIP_SH = 37;

    typedef struct packed {
        logic       latch;
        logic       wrap;
        logic       setpos;
        logic       frame_start;
        logic       drain_end;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       sum;
        logic       prod;
        logic       scale;
        logic       recip;
        logic       load_out;
        logic       wr;
        logic       adv_in;
        logic       adv_out;
    } t_cmd;

    typedef struct packed {
        logic is_drain;
        logic pending;
        logic out_ge_h;
        logic row_ge2;
        logic interior;
        logic out_busy;
    } t_stat;

    function automatic logic [11:0] warm_of(input logic [1:0] c);
        logic [11:0] v;
        case (c)
            2'd0:    v = 12'd2913;
            2'd1:    v = 12'd2702;
            default: v = 12'd2020;
        endcase
        return v;
    endfunction

    function automatic logic [11:0] triad_of(input logic [1:0] c);
        return (c == 2'd1) ? 12'd2560 : 12'd3072;
    endfunction

endpackage

>>> rtl/crt_scanline_bloom_filter.sv
// CRT scanline bloom filter, top level: sequencer plus datapath.
// Depends on csbf_pkg, csbf_ctrl, csbf_dp (and csbf_ram below it).
//
// Input channel (i_valid/o_ready): one item per raster pixel, or a drain
// tick (i_func = 1) that flushes the last two rows after a frame ends.
// Output channel (o_valid/i_ready): the pixel two rows back, with x, y
// and o_frame_end on the last pixel of the frame.
// Config: i_cfg_we writes frame width (index 0) or height (index 1);
// write only while idle.
// One item at a time. Pixels in the top two rows are only stored; border
// pixels also read their centre and emit, and interior pixels make four
// reads through the single read port of the line store and run the bloom
// multiply chain. A drain tick reads and emits one stored pixel; an
// ignored one ends after the check. The output register loads in the emit step.
// The next item is taken while a result waits in the output register;
// a stall of the receiver holds the block in its emit step until the
// register frees. Reset restores 640 x 480, clears positions and any
// pending drain; the line store needs no clearing.
module crt_scanline_bloom_filter import csbf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_func,
    input  logic [7:0]       i_in_red,
    input  logic [7:0]       i_in_green,
    input  logic [7:0]       i_in_blue,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [9:0]       o_out_x,
    output logic [9:0]       o_out_y,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_frame_end
);
    t_cmd  cmd;
    t_stat stat;

    csbf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    csbf_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_frame_end (o_frame_end),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );
endmodule

>>> rtl/csbf_ram.sv
// Generic simple dual-port RAM with registered read data.
// No dependencies.
module csbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/csbf_ctrl.sv
// Sequencer of the CRT scanline bloom filter: one item at a time.
// Depends on csbf_pkg; drives the datapath by t_cmd, reads t_stat.
module csbf_ctrl import csbf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RESOLVE = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_RD_C    = 4'd3;
    localparam logic [3:0] S_CAP_C   = 4'd4;
    localparam logic [3:0] S_CAP_L   = 4'd5;
    localparam logic [3:0] S_CAP_R   = 4'd6;
    localparam logic [3:0] S_CAP_U   = 4'd7;
    localparam logic [3:0] S_SUM     = 4'd8;
    localparam logic [3:0] S_PROD    = 4'd9;
    localparam logic [3:0] S_SCALE   = 4'd10;
    localparam logic [3:0] S_RECIP   = 4'd11;
    localparam logic [3:0] S_EMIT    = 4'd12;
    localparam logic [3:0] S_WRITE   = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.is_drain) begin
                    if (!i_stat.pending) begin
                        n_state = S_IDLE;
                    end else if (i_stat.out_ge_h) begin
                        o_cmd.drain_end = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.setpos = 1'b1;
                        n_state      = S_RD_C;
                    end
                end else begin
                    o_cmd.frame_start = 1'b1;
                    o_cmd.setpos      = 1'b1;
                    n_state           = i_stat.row_ge2 ? S_RD_C : S_WRITE;
                end
            end
            S_RD_C: begin
                o_cmd.rd_sel = RD_CTR;
                n_state      = S_CAP_C;
            end
            S_CAP_C: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_CTR;
                o_cmd.rd_sel  = RD_LEFT;
                n_state = (!i_stat.is_drain && i_stat.interior) ? S_CAP_L : S_EMIT;
            end
            S_CAP_L: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_LEFT;
                o_cmd.rd_sel  = RD_RIGHT;
                n_state       = S_CAP_R;
            end
            S_CAP_R: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_RIGHT;
                o_cmd.rd_sel  = RD_UP;
                n_state       = S_CAP_U;
            end
            S_CAP_U: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = RD_UP;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_RECIP;
            end
            S_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    if (i_stat.is_drain) begin
                        o_cmd.adv_out = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                o_cmd.wr     = 1'b1;
                o_cmd.adv_in = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/csbf_dp.sv
// Datapath of the CRT scanline bloom filter: position counters, line
// store, bloom arithmetic and output register. Depends on csbf_pkg, csbf_ram.
module csbf_dp import csbf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_func,
    input  logic [7:0]       i_in_red,
    input  logic [7:0]       i_in_green,
    input  logic [7:0]       i_in_blue,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [9:0]       o_out_x,
    output logic [9:0]       o_out_y,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic             o_frame_end,
    input  t_cmd             i_cmd,
    output t_stat            o_stat
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(4 * MAX_WIDTH);
    localparam int FW = (WW > CFG_W) ? WW : CFG_W;
    localparam int FH = (HW > CFG_W) ? HW : CFG_W;

    logic [CFG_W-1:0] r_fw, r_fh;
    logic [WW-1:0]    w_eff, r_ic, r_oc, r_x;
    logic [HW-1:0]    h_eff, r_ir, r_or, r_y;
    logic [1:0]       r_ic3, r_oc3, r_x3;
    logic             r_pend, r_func, r_ov;
    logic [PIX_W-1:0] r_cur, r_ctr, r_nl, r_nr, r_nu, rdata;
    logic [9:0]       r_s [3];
    logic [9:0]       r_m;
    logic             r_over;
    logic [18:0]      r_p1 [3];
    logic [25:0]      r_p2 [3];
    logic [14:0]      r_add [3];
    logic [9:0]       r_ox, r_oy;
    logic [7:0]       r_ored, r_ogreen, r_oblue;
    logic             r_ofe;
    logic [AW-1:0]    raddr, waddr;
    logic [7:0]       res [3];
    logic             fe;
    logic [WW:0]      ic_p2;
    logic [WW:0]      ic_p1;
    logic [HW:0]      ir_p1;

    function automatic logic [AW-1:0] slot(input logic [1:0] row, input logic [WW-1:0] col);
        return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    function automatic logic [1:0] step3(input logic [1:0] p);
        return (p == 2'd2) ? 2'd0 : p + 2'd1;
    endfunction

    always_comb begin
        if (r_fw == '0) begin
            w_eff = WW'(1);
        end else if (FW'(r_fw) > FW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_fw);
        end
        if (r_fh == '0) begin
            h_eff = HW'(1);
        end else if (FH'(r_fh) > FH'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_fh);
        end
    end

    assign ic_p2 = {1'b0, r_ic} + (WW+1)'(2);
    assign ic_p1 = {1'b0, r_ic} + (WW+1)'(1);
    assign ir_p1 = {1'b0, r_ir} + (HW+1)'(1);

    assign o_stat.is_drain = r_func;
    assign o_stat.pending  = r_pend;
    assign o_stat.out_ge_h = (r_or >= h_eff);
    assign o_stat.row_ge2  = (r_ir >= HW'(2));
    assign o_stat.interior = (r_ic >= WW'(2)) && (ic_p2 < {1'b0, w_eff}) && (r_ir >= HW'(4));
    assign o_stat.out_busy = r_ov && !i_ready;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LEFT:  raddr = slot(r_y[1:0], r_x - WW'(2));
            RD_RIGHT: raddr = slot(r_y[1:0], r_x + WW'(2));
            RD_UP:    raddr = slot(r_y[1:0] + 2'd2, r_x);
            default:  raddr = slot(r_y[1:0], r_x);
        endcase
    end
    assign waddr = slot(r_y[1:0] + 2'd2, r_x);

    csbf_ram #(.WIDTH(PIX_W), .DEPTH(4 * MAX_WIDTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (waddr),
        .i_wdata (r_cur),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        logic [7:0]  ch;
        logic [16:0] v;
        for (int c = 0; c < 3; c++) begin
            ch = r_ctr[PIX_W-1-8*c -: 8];
            v  = (r_y[1:0] == 2'd3) ? 17'(ch) * 17'(DARK_MUL) : {1'b0, ch, 8'b0};
            if (r_y[1:0] == 2'd0) begin
                v = v + 17'(warm_of(2'(c)));
            end
            if (r_x3 == 2'(c)) begin
                v = v + 17'(triad_of(2'(c)));
            end
            v = v + 17'(r_add[c]);
            res[c] = v[16] ? 8'hFF : v[15:8];
        end
    end

    assign fe = r_func && (r_x == w_eff - WW'(1)) && (r_y == h_eff - HW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw   <= DEF_WIDTH;
            r_fh   <= DEF_HEIGHT;
            r_ic   <= '0;
            r_ir   <= '0;
            r_ic3  <= '0;
            r_oc   <= '0;
            r_or   <= '0;
            r_oc3  <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                    REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                endcase
            end
            if (i_cmd.wrap) begin
                if (r_func) begin
                    if (r_oc >= w_eff) begin
                        r_oc  <= '0;
                        r_oc3 <= '0;
                        r_or  <= r_or + HW'(1);
                    end
                end else if (r_ic >= w_eff) begin
                    r_ic  <= '0;
                    r_ic3 <= '0;
                    r_ir  <= (ir_p1 >= {1'b0, h_eff}) ? '0 : HW'(ir_p1);
                end else if (r_ir >= h_eff) begin
                    r_ir <= '0;
                end
            end
            if (i_cmd.frame_start && r_ic == '0 && r_ir == '0) begin
                r_pend <= 1'b0;
                r_oc   <= '0;
                r_or   <= '0;
                r_oc3  <= '0;
            end
            if (i_cmd.drain_end) begin
                r_pend <= 1'b0;
                r_oc   <= '0;
                r_or   <= '0;
                r_oc3  <= '0;
            end
            if (i_cmd.adv_out) begin
                if (fe) begin
                    r_pend <= 1'b0;
                    r_oc   <= '0;
                    r_or   <= '0;
                    r_oc3  <= '0;
                end else begin
                    r_oc  <= r_oc + WW'(1);
                    r_oc3 <= step3(r_oc3);
                end
            end
            if (i_cmd.adv_in) begin
                if (ic_p1 >= {1'b0, w_eff}) begin
                    r_ic  <= '0;
                    r_ic3 <= '0;
                    if (ir_p1 >= {1'b0, h_eff}) begin
                        r_ir   <= '0;
                        r_pend <= 1'b1;
                        r_oc   <= '0;
                        r_oc3  <= '0;
                        r_or   <= (h_eff >= HW'(2)) ? h_eff - HW'(2) : '0;
                    end else begin
                        r_ir <= HW'(ir_p1);
                    end
                end else begin
                    r_ic  <= WW'(ic_p1);
                    r_ic3 <= step3(r_ic3);
                end
            end
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [9:0]  sv [3];
        logic [9:0]  mv;
        logic [51:0] pr;
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_cur  <= {i_in_red, i_in_green, i_in_blue};
        end
        if (i_cmd.setpos) begin
            for (int c = 0; c < 3; c++) begin
                r_add[c] <= '0;
            end
            if (r_func) begin
                r_x  <= r_oc;
                r_x3 <= r_oc3;
                r_y  <= r_or;
            end else begin
                r_x  <= r_ic;
                r_x3 <= r_ic3;
                r_y  <= r_ir - HW'(2);
            end
        end
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                RD_LEFT:  r_nl  <= rdata;
                RD_RIGHT: r_nr  <= rdata;
                RD_UP:    r_nu  <= rdata;
                default:  r_ctr <= rdata;
            endcase
        end
        if (i_cmd.sum) begin
            mv = '0;
            for (int c = 0; c < 3; c++) begin
                sv[c] = 10'(r_nl[PIX_W-1-8*c -: 8]) + 10'(r_nr[PIX_W-1-8*c -: 8])
                      + 10'(r_nu[PIX_W-1-8*c -: 8]) + 10'(r_cur[PIX_W-1-8*c -: 8]);
                r_s[c] <= sv[c];
                if (sv[c] > mv) begin
                    mv = sv[c];
                end
            end
            r_m <= mv;
        end
        if (i_cmd.prod) begin
            r_over <= (r_m > KNEE_SUM);
            for (int c = 0; c < 3; c++) begin
                r_p1[c] <= 19'(r_s[c]) * 19'(r_m - KNEE_SUM);
            end
        end
        if (i_cmd.scale) begin
            for (int c = 0; c < 3; c++) begin
                r_p2[c] <= (26'(r_p1[c]) << 7) - (26'(r_p1[c]) << 4);
            end
        end
        if (i_cmd.recip) begin
            for (int c = 0; c < 3; c++) begin
                pr = 52'(r_p2[c]) * 52'(RECIP);
                r_add[c] <= r_over ? pr[RECIP_SH +: 15] : '0;
            end
        end
        if (i_cmd.load_out) begin
            r_ox     <= 10'(r_x);
            r_oy     <= 10'(r_y);
            r_ored   <= res[0];
            r_ogreen <= res[1];
            r_oblue  <= res[2];
            r_ofe    <= fe;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_red   = r_ored;
    assign o_out_green = r_ogreen;
    assign o_out_blue  = r_oblue;
    assign o_frame_end = r_ofe;
endmodule

>>> tb/csbf_checker.sv
// Checker for the CRT scanline bloom filter: watches the config port and both
// item channels, predicts each filtered pixel and compares it with the output.
// Depends on csbf_pkg; instantiated by tb_crt_scanline_bloom_filter.
module csbf_checker import csbf_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    input  logic             i_ready_in,
    input  logic             i_func,
    input  logic [7:0]       i_in_red,
    input  logic [7:0]       i_in_green,
    input  logic [7:0]       i_in_blue,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [9:0]       i_out_x,
    input  logic [9:0]       i_out_y,
    input  logic [7:0]       i_out_red,
    input  logic [7:0]       i_out_green,
    input  logic [7:0]       i_out_blue,
    input  logic             i_frame_end,
    output int               o_errors,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_pix;

    localparam int unsigned WARM_ADD  [3] = '{2913, 2702, 2020};
    localparam int unsigned TRIAD_ADD [3] = '{3072, 2560, 3072};

    logic [23:0]  line_mem [0:4*MAX_WIDTH-1];
    int unsigned  in_col, in_row, drn_col, drn_row;
    bit           draining;
    logic [10:0]  width_reg, height_reg;
    t_pix         pix_due_q[$];

    initial begin
        o_errors = 0;
        o_outstanding = 0;
        foreach (line_mem[i]) line_mem[i] = '0;
    end

    function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned mx);
        if (v < 1) return 1;
        return (v > mx) ? mx : v;
    endfunction

    function automatic int unsigned slot_of(int unsigned row, int unsigned col);
        return (row % 4) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    function automatic t_pix shade(logic [23:0] px, int unsigned x, int unsigned y,
                                   int unsigned bloom [3]);
        t_pix        p;
        int unsigned v, ch;
        logic [7:0]  res [3];
        for (int c = 0; c < 3; c++) begin
            ch = px[23-8*c -: 8];
            v = (y % 4 == 3) ? ch * DARK_MUL : ch * 256;
            if (y % 4 == 0) v += WARM_ADD[c];
            if (x % 3 == c) v += TRIAD_ADD[c];
            v = (v + bloom[c]) >> 8;
            res[c] = (v > 255) ? 8'd255 : v[7:0];
        end
        p.x = x[9:0];
        p.y = y[9:0];
        p.red = res[0];
        p.green = res[1];
        p.blue = res[2];
        p.last = 1'b0;
        return p;
    endfunction

    task automatic take_item(bit drain_tick, logic [23:0] cur);
        int unsigned w, h, x, r, y, m;
        int unsigned bloom [3];
        int unsigned sums [3];
        logic [23:0] nb [4];
        t_pix        p;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        bloom = '{0, 0, 0};
        if (drain_tick) begin
            if (!draining) return;
            if (drn_col >= w) begin
                drn_col = 0;
                drn_row++;
            end
            if (drn_row >= h) begin
                draining = 0;
                drn_col = 0;
                drn_row = 0;
                return;
            end
            p = shade(line_mem[slot_of(drn_row, drn_col)], drn_col, drn_row, bloom);
            if (drn_col == w - 1 && drn_row == h - 1) begin
                p.last = 1'b1;
                draining = 0;
                drn_col = 0;
                drn_row = 0;
            end else begin
                drn_col++;
            end
            pix_due_q.push_back(p);
            return;
        end
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (in_row >= h) in_row = 0;
        x = in_col;
        r = in_row;
        if (x == 0 && r == 0) begin
            draining = 0;
            drn_col = 0;
            drn_row = 0;
        end
        if (r >= 2) begin
            y = r - 2;
            if (x >= 2 && x + 2 < w && y >= 2) begin
                nb[0] = line_mem[slot_of(y, x - 2)];
                nb[1] = line_mem[slot_of(y, x + 2)];
                nb[2] = line_mem[slot_of(r, x)];
                nb[3] = cur;
                m = 0;
                for (int c = 0; c < 3; c++) begin
                    sums[c] = 0;
                    for (int k = 0; k < 4; k++) sums[c] += nb[k][23-8*c -: 8];
                    if (sums[c] > m) m = sums[c];
                end
                if (m > KNEE_SUM)
                    for (int c = 0; c < 3; c++)
                        bloom[c] = (sums[c] * (m - KNEE_SUM) * 112) / 2295;
            end
            pix_due_q.push_back(shade(line_mem[slot_of(y, x)], x, y, bloom));
        end
        line_mem[slot_of(r, x)] = cur;
        in_col = x + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = r + 1;
            if (in_row >= h) begin
                in_row = 0;
                draining = 1;
                drn_col = 0;
                drn_row = (h >= 2) ? h - 2 : 0;
            end
        end
    endtask

    task automatic check_pixel();
        t_pix p;
        if (pix_due_q.size() == 0) begin
            $error("unexpected output item x=%0d y=%0d", i_out_x, i_out_y);
            o_errors++;
            return;
        end
        p = pix_due_q.pop_front();
        if (i_out_x !== p.x) begin
            $error("out_x: expected %0d, got %0d", p.x, i_out_x);
            o_errors++;
        end
        if (i_out_y !== p.y) begin
            $error("out_y: expected %0d, got %0d", p.y, i_out_y);
            o_errors++;
        end
        if (i_out_red !== p.red) begin
            $error("out_red: expected %0d, got %0d", p.red, i_out_red);
            o_errors++;
        end
        if (i_out_green !== p.green) begin
            $error("out_green: expected %0d, got %0d", p.green, i_out_green);
            o_errors++;
        end
        if (i_out_blue !== p.blue) begin
            $error("out_blue: expected %0d, got %0d", p.blue, i_out_blue);
            o_errors++;
        end
        if (i_frame_end !== p.last) begin
            $error("frame_end: expected %0d, got %0d", p.last, i_frame_end);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_col = 0;
            in_row = 0;
            drn_col = 0;
            drn_row = 0;
            draining = 0;
            width_reg = DEF_WIDTH;
            height_reg = DEF_HEIGHT;
            pix_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_FRAME_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) check_pixel();
            if (i_valid && i_ready_in)
                take_item(i_func, {i_in_red, i_in_green, i_in_blue});
        end
        o_outstanding = pix_due_q.size();
    end
endmodule

>>> tb/tb_crt_scanline_bloom_filter.sv
// Testbench top for crt_scanline_bloom_filter: clock, reset, config writes,
// pixel and drain stimulus with idle phases; csbf_checker judges the results.
// Depends on csbf_pkg, crt_scanline_bloom_filter and csbf_checker.
module tb_crt_scanline_bloom_filter;
    import csbf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic             i_func = 1'b0;
    logic [7:0]       i_in_red = '0;
    logic [7:0]       i_in_green = '0;
    logic [7:0]       i_in_blue = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [9:0]       o_out_x, o_out_y;
    logic [7:0]       o_out_red, o_out_green, o_out_blue;
    logic             o_frame_end;

    int errors, outstanding;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_kick = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always #4 i_clk = ~i_clk;

    crt_scanline_bloom_filter dut (.*);

    csbf_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_func,
        .i_in_red, .i_in_green, .i_in_blue,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_red(o_out_red), .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .i_frame_end(o_frame_end),
        .o_errors(errors), .o_outstanding(outstanding)
    );

    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= 300;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        #8ms;
        $display("FAIL crt_scanline_bloom_filter");
        $finish;
    end

    task automatic send(bit drain_tick, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= drain_tick;
        i_in_red <= r;
        i_in_green <= g;
        i_in_blue <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_rand_pixel();
        if ($urandom_range(3) == 0)
            send(1'b0, 8'($urandom_range(140, 255)), 8'($urandom_range(140, 255)),
                 8'($urandom_range(140, 255)));
        else
            send(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    endtask

    task automatic run_frame(int w, int h, bit noise, bit drain);
        int n_drain;
        for (int i = 0; i < w * h; i++) begin
            if (noise && i > 0 && $urandom_range(19) == 0) send(1'b1, '1, '1, '1);
            send_rand_pixel();
        end
        n_drain = 2 * w + int'($urandom_range(2));
        if (drain)
            for (int i = 0; i < n_drain; i++)
                send(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    endtask

    initial begin
        int w, h, sent;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, bloom, drain, abandon, shrink mid-frame
        set_frame(5, 5);
        send(1'b1, '0, '0, '0);
        for (int i = 0; i < 25; i++) begin
            case (i % 4)
                0:       send(1'b0, 8'hff, 8'hff, 8'hff);
                1:       send(1'b0, 8'h00, 8'h00, 8'h00);
                2:       send(1'b0, 8'hff, 8'h00, 8'haa);
                default: send(1'b0, 8'h55, 8'hff, 8'h00);
            endcase
        end
        for (int i = 0; i < 12; i++) send(1'b1, '0, '0, '0);
        set_frame(3, 2);
        run_frame(3, 2, 0, 0);
        set_frame(6, 6);
        for (int i = 0; i < 14; i++) send_rand_pixel();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(4));
        for (int i = 0; i < 6; i++) send_rand_pixel();
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
        run_frame(4, 3, 0, 0);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
        send(1'b1, '0, '0, '0);
        send(1'b1, '0, '0, '0);

        // register extremes, no idling
        set_frame(0, 6);
        run_frame(1, 6, 0, 1);
        set_frame(7, 0);
        run_frame(7, 1, 1, 1);

        // random frames over the idling phases
        w = 5;
        h = 5;
        set_frame(w, h);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 33; stall_pct = 33; end
            endcase
            sent = 0;
            while (sent < 100) begin
                if (ph == 0 && sent == 0) hold_kick++;
                run_frame(w, h, 1, $urandom_range(9) < 7);
                sent += w * h;
                if ($urandom_range(1) == 0) begin
                    w = $urandom_range(1, 9);
                    h = $urandom_range(1, 7);
                    set_frame(w, h);
                end
            end
            wait_idle();
        end

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (errors == 0)
            $display("PASS crt_scanline_bloom_filter");
        else
            $display("FAIL crt_scanline_bloom_filter");
        $finish;
    end
endmodule
